// ----- rtl/tcgr_pkg.sv -----
// tcgr_pkg: shared constants, codes and types of the text console glyph renderer.
// Used by every module under rtl/ but tcgr_ram; depends on nothing.
`default_nettype none

package tcgr_pkg;

    // Font geometry
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_WIDTH  = 8;
    localparam int FONT_CHARS   = 256;
    localparam int STORE_DEPTH  = FONT_CHARS * GLYPH_HEIGHT;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int ROW_W        = $clog2(GLYPH_HEIGHT);

    // Screen limits
    localparam logic [12:0] WIDTH_MIN  = 13'd8;
    localparam logic [12:0] WIDTH_MAX  = 13'd4096;
    localparam logic [12:0] HEIGHT_MIN = 13'd16;
    localparam logic [12:0] HEIGHT_MAX = 13'd4096;
    localparam logic [12:0] ROWS_MAX   = 13'd256;

    // Queues (depths are powers of two)
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_LVL_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUT_DEPTH  = 4;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_LVL_W  = $clog2(OUT_DEPTH + 1);
    localparam int OUT_SUM_W  = OUT_LVL_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // Input command codes
    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    // Special character codes
    localparam logic [7:0] CODE_NULL      = 8'd0;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;

    // Result kinds
    localparam logic [1:0] KIND_GLYPH  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    typedef enum logic [2:0] {
        OP_NULL,
        OP_PRINT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_LOAD,
        OP_COMMIT
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GLYPH,
        ST_SCROLL
    } back_state_t;

    // Classified command between front and back
    typedef struct packed {
        op_t                 op;
        logic                blank;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          bits;
    } cmd_t;

    typedef struct packed {
        logic [12:0] left;
        logic [12:0] top;
        logic [12:0] right;
        logic [12:0] bottom;
    } rect_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  pattern;
        logic        dirty_valid;
        rect_t       rect;
        logic        last;
    } result_t;

    // Screen geometry derived from the configuration registers
    typedef struct packed {
        logic [9:0]  cols;
        logic [8:0]  rows;
        logic [12:0] width;
        logic [12:0] height;
    } geom_t;

    // Font store access from the back end
    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- rtl/tcgr_ram.sv -----
// tcgr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/tcgr_front.sv -----
// tcgr_front: accepts input items, classifies them and queues them for the back end.
// Depends on tcgr_pkg.
`default_nettype none

module tcgr_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  char_code,
    input  wire logic [3:0]  font_row,
    input  wire logic [7:0]  font_bits,
    output tcgr_pkg::cmd_t   head,
    output logic             head_valid,
    input  wire logic        head_pop
);

    tcgr_pkg::cmd_t                       q_reg [tcgr_pkg::CMDQ_DEPTH];
    logic [tcgr_pkg::CMDQ_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tcgr_pkg::CMDQ_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tcgr_pkg::CMDQ_LVL_W-1:0]      count_reg, count_next;

    tcgr_pkg::cmd_t entry;
    logic           keep;
    logic           wr;
    logic           rd;
    logic           code_in_font;
    logic           row_in_glyph;
    logic [tcgr_pkg::STORE_AW-1:0] base_addr;
    logic [tcgr_pkg::STORE_AW-1:0] load_addr;

    assign code_in_font = (9'(char_code) < 9'(tcgr_pkg::FONT_CHARS));
    assign row_in_glyph = (6'(font_row) < 6'(tcgr_pkg::GLYPH_HEIGHT));
    assign base_addr    = tcgr_pkg::STORE_AW'(int'(char_code) * tcgr_pkg::GLYPH_HEIGHT);
    assign load_addr    = tcgr_pkg::STORE_AW'(int'(char_code) * tcgr_pkg::GLYPH_HEIGHT
                                              + int'(font_row));

    // Classify; unknown commands and out-of-range font loads are dropped here
    always_comb
    begin
        keep        = 1'b0;
        entry.op    = tcgr_pkg::OP_NULL;
        entry.blank = !code_in_font;
        entry.addr  = base_addr;
        entry.bits  = font_bits;
        unique case (command)
            tcgr_pkg::CMD_PUT:
            begin
                keep = 1'b1;
                unique case (char_code)
                    tcgr_pkg::CODE_NULL:      entry.op = tcgr_pkg::OP_NULL;
                    tcgr_pkg::CODE_NEWLINE:   entry.op = tcgr_pkg::OP_NEWLINE;
                    tcgr_pkg::CODE_BACKSPACE: entry.op = tcgr_pkg::OP_BACKSPACE;
                    default:                  entry.op = tcgr_pkg::OP_PRINT;
                endcase
            end
            tcgr_pkg::CMD_LOAD:
            begin
                keep       = code_in_font && row_in_glyph;
                entry.op   = tcgr_pkg::OP_LOAD;
                entry.addr = load_addr;
            end
            tcgr_pkg::CMD_COMMIT:
            begin
                keep     = 1'b1;
                entry.op = tcgr_pkg::OP_COMMIT;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full       = (count_reg == tcgr_pkg::CMDQ_LVL_W'(tcgr_pkg::CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign wr         = push && !full && keep;
    assign rd         = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr ? tcgr_pkg::CMDQ_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd ? tcgr_pkg::CMDQ_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = tcgr_pkg::CMDQ_LVL_W'(count_reg + tcgr_pkg::CMDQ_LVL_W'(wr)
                                            - tcgr_pkg::CMDQ_LVL_W'(rd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcgr_result_fifo.sv -----
// tcgr_result_fifo: small queue of finished result items toward the output ports.
// Depends on tcgr_pkg.
`default_nettype none

module tcgr_result_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire tcgr_pkg::result_t           wr_data,
    input  wire logic                        pop,
    output logic                             empty,
    output tcgr_pkg::result_t                rd_data,
    output logic [tcgr_pkg::OUT_LVL_W-1:0]   level
);

    tcgr_pkg::result_t                  fifo_reg [tcgr_pkg::OUT_DEPTH];
    logic [tcgr_pkg::OUT_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tcgr_pkg::OUT_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tcgr_pkg::OUT_LVL_W-1:0]     count_reg, count_next;
    logic                               rd;

    // The back end never writes without room, so no full check here
    assign empty   = (count_reg == '0);
    assign rd      = pop && !empty;
    assign rd_data = fifo_reg[rd_ptr_reg];
    assign level   = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_en ? tcgr_pkg::OUT_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd ? tcgr_pkg::OUT_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = tcgr_pkg::OUT_LVL_W'(count_reg + tcgr_pkg::OUT_LVL_W'(wr_en)
                                           - tcgr_pkg::OUT_LVL_W'(rd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcgr_back.sv -----
// tcgr_back: executes classified commands: cursor, dirty rectangle, glyph row reads.
// Depends on tcgr_pkg; drives the font RAM and the result fifo.
`default_nettype none

module tcgr_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tcgr_pkg::geom_t                geom,
    input  wire tcgr_pkg::cmd_t                 head,
    input  wire logic                           head_valid,
    output logic                                head_pop,
    output tcgr_pkg::ram_req_t                  ram_req,
    input  wire logic [7:0]                     ram_rdata,
    input  wire logic [tcgr_pkg::OUT_LVL_W-1:0] out_level,
    output logic                                out_wr,
    output tcgr_pkg::result_t                   out_data
);

    tcgr_pkg::back_state_t          state_reg, state_next;
    logic [8:0]                     col_reg, col_next;
    logic [7:0]                     row_reg, row_next;
    logic                           flag_reg, flag_next;
    tcgr_pkg::rect_t                dirty_reg, dirty_next;
    logic [tcgr_pkg::STORE_AW-1:0]  g_addr_reg, g_addr_next;
    logic                           g_blank_reg, g_blank_next;
    logic [11:0]                    g_x_reg, g_x_next;
    logic [11:0]                    g_y_reg, g_y_next;
    logic [tcgr_pkg::ROW_W-1:0]     v_reg, v_next;
    logic                           ev_reg, ev_next;
    tcgr_pkg::result_t              e_reg, e_next;
    logic                           e_ram_reg, e_ram_next;

    logic            space_ok;
    logic [8:0]      eff_col;
    logic [7:0]      eff_row;
    logic [8:0]      last_col;
    logic [7:0]      last_row;
    logic [11:0]     x_cur;
    logic [12:0]     y_cur;
    tcgr_pkg::rect_t glyph_rect;
    tcgr_pkg::rect_t scroll_rect;
    logic            col_wrap;
    logic            row_wrap_g;
    logic            row_wrap_n;
    logic            last_v;

    function automatic tcgr_pkg::rect_t grow(input logic flag, input tcgr_pkg::rect_t cur,
                                             input tcgr_pkg::rect_t add);
        tcgr_pkg::rect_t r;
        r = cur;
        if (!flag)
        begin
            r = add;
        end
        else
        begin
            if (add.left < cur.left)
                r.left = add.left;
            if (add.top < cur.top)
                r.top = add.top;
            if (add.right > cur.right)
                r.right = add.right;
            if (add.bottom > cur.bottom)
                r.bottom = add.bottom;
        end
        return r;
    endfunction

    // Room for one more result beyond the one already in flight
    assign space_ok = (tcgr_pkg::OUT_SUM_W'(out_level) + tcgr_pkg::OUT_SUM_W'(ev_reg))
                      < tcgr_pkg::OUT_SUM_W'(tcgr_pkg::OUT_DEPTH);

    assign last_col = 9'(geom.cols - 10'd1);
    assign last_row = 8'(geom.rows - 9'd1);
    assign eff_col  = (10'(col_reg) >= geom.cols) ? last_col : col_reg;
    assign eff_row  = (9'(row_reg) >= geom.rows) ? last_row : row_reg;

    assign x_cur = 12'(int'(eff_col) * tcgr_pkg::GLYPH_WIDTH);
    assign y_cur = 13'(int'(eff_row) * tcgr_pkg::GLYPH_HEIGHT);

    assign glyph_rect.left   = 13'(x_cur);
    assign glyph_rect.top    = y_cur;
    assign glyph_rect.right  = 13'(x_cur) + 13'(tcgr_pkg::GLYPH_WIDTH);
    assign glyph_rect.bottom = y_cur + 13'(tcgr_pkg::GLYPH_HEIGHT);

    assign scroll_rect.left   = '0;
    assign scroll_rect.top    = '0;
    assign scroll_rect.right  = geom.width;
    assign scroll_rect.bottom = geom.height;

    assign col_wrap   = ((10'(col_reg) + 10'd1) >= geom.cols);
    assign row_wrap_g = ((9'(row_reg) + 9'd1) >= geom.rows);
    assign row_wrap_n = ((9'(eff_row) + 9'd1) >= geom.rows);
    assign last_v     = (v_reg == tcgr_pkg::ROW_W'(tcgr_pkg::GLYPH_HEIGHT - 1));

    always_comb
    begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        flag_next    = flag_reg;
        dirty_next   = dirty_reg;
        g_addr_next  = g_addr_reg;
        g_blank_next = g_blank_reg;
        g_x_next     = g_x_reg;
        g_y_next     = g_y_reg;
        v_next       = v_reg;
        ev_next      = 1'b0;
        e_next       = e_reg;
        e_ram_next   = 1'b0;
        head_pop     = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = head.addr;
        ram_req.wdata = head.bits;
        ram_req.re    = 1'b0;
        ram_req.raddr = tcgr_pkg::STORE_AW'(g_addr_reg + tcgr_pkg::STORE_AW'(v_reg));

        unique case (state_reg)
            tcgr_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head.op)
                        tcgr_pkg::OP_LOAD:
                        begin
                            ram_req.we = 1'b1;
                            head_pop   = 1'b1;
                        end
                        tcgr_pkg::OP_COMMIT:
                        begin
                            if (space_ok)
                            begin
                                head_pop           = 1'b1;
                                ev_next            = 1'b1;
                                e_next             = '0;
                                e_next.kind        = tcgr_pkg::KIND_REPORT;
                                e_next.dirty_valid = flag_reg;
                                e_next.rect        = dirty_reg;
                                e_next.last        = 1'b1;
                                flag_next          = 1'b0;
                                dirty_next         = '0;
                            end
                        end
                        tcgr_pkg::OP_NULL:
                        begin
                            head_pop = 1'b1;
                            col_next = eff_col;
                            row_next = eff_row;
                        end
                        tcgr_pkg::OP_BACKSPACE:
                        begin
                            head_pop = 1'b1;
                            if (eff_col == '0)
                            begin
                                if (eff_row == '0)
                                begin
                                    col_next = '0;
                                    row_next = '0;
                                end
                                else
                                begin
                                    col_next = last_col;
                                    row_next = eff_row - 8'd1;
                                end
                            end
                            else
                            begin
                                col_next = eff_col - 9'd1;
                                row_next = eff_row;
                            end
                        end
                        tcgr_pkg::OP_NEWLINE:
                        begin
                            if (space_ok)
                            begin
                                head_pop = 1'b1;
                                col_next = '0;
                                if (row_wrap_n)
                                begin
                                    row_next    = last_row;
                                    flag_next   = 1'b1;
                                    dirty_next  = grow(flag_reg, dirty_reg, scroll_rect);
                                    ev_next     = 1'b1;
                                    e_next      = '0;
                                    e_next.kind = tcgr_pkg::KIND_SCROLL;
                                    e_next.last = 1'b1;
                                end
                                else
                                begin
                                    row_next = 8'(9'(eff_row) + 9'd1);
                                end
                            end
                        end
                        tcgr_pkg::OP_PRINT:
                        begin
                            head_pop     = 1'b1;
                            col_next     = eff_col;
                            row_next     = eff_row;
                            flag_next    = 1'b1;
                            dirty_next   = grow(flag_reg, dirty_reg, glyph_rect);
                            g_addr_next  = head.addr;
                            g_blank_next = head.blank;
                            g_x_next     = x_cur;
                            g_y_next     = 12'(y_cur);
                            v_next       = '0;
                            state_next   = tcgr_pkg::ST_GLYPH;
                        end
                        default:
                        begin
                            head_pop = 1'b1;
                        end
                    endcase
                end
            end

            tcgr_pkg::ST_GLYPH:
            begin
                // One glyph row per cycle while the result fifo has room: read now, pattern joins the item next cycle
                if (space_ok)
                begin
                    ram_req.re     = !g_blank_reg;
                    ev_next        = 1'b1;
                    e_ram_next     = !g_blank_reg;
                    e_next         = '0;
                    e_next.kind    = tcgr_pkg::KIND_GLYPH;
                    e_next.pixel_x = g_x_reg;
                    e_next.pixel_y = 12'(g_y_reg + 12'(v_reg));
                    v_next         = tcgr_pkg::ROW_W'(v_reg + 1'b1);
                    e_next.last    = last_v;
                    if (last_v)
                    begin
                        state_next = tcgr_pkg::ST_IDLE;
                        if (col_wrap)
                        begin
                            col_next = '0;
                            if (row_wrap_g)
                            begin
                                row_next    = last_row;
                                e_next.last = 1'b0;
                                state_next  = tcgr_pkg::ST_SCROLL;
                            end
                            else
                            begin
                                row_next = 8'(9'(row_reg) + 9'd1);
                            end
                        end
                        else
                        begin
                            col_next = 9'(10'(col_reg) + 10'd1);
                        end
                    end
                end
            end

            tcgr_pkg::ST_SCROLL:
            begin
                if (space_ok)
                begin
                    flag_next   = 1'b1;
                    dirty_next  = grow(flag_reg, dirty_reg, scroll_rect);
                    ev_next     = 1'b1;
                    e_next      = '0;
                    e_next.kind = tcgr_pkg::KIND_SCROLL;
                    e_next.last = 1'b1;
                    state_next  = tcgr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_wr           = ev_reg;
        out_data         = e_reg;
        out_data.pattern = e_ram_reg ? ram_rdata : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcgr_pkg::ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            flag_reg  <= 1'b0;
            dirty_reg <= '0;
            v_reg     <= '0;
            ev_reg    <= 1'b0;
            e_ram_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            flag_reg  <= flag_next;
            dirty_reg <= dirty_next;
            v_reg     <= v_next;
            ev_reg    <= ev_next;
            e_ram_reg <= e_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_addr_reg  <= g_addr_next;
        g_blank_reg <= g_blank_next;
        g_x_reg     <= g_x_next;
        g_y_reg     <= g_y_next;
        e_reg       <= e_next;
    end

endmodule

`default_nettype wire

// ----- rtl/text_console_glyph_renderer.sv -----
// Text console glyph renderer, top level: config registers, front, back, font RAM, result fifo.
// Depends on tcgr_pkg, tcgr_ram, tcgr_front, tcgr_back, tcgr_result_fifo.
// A print dispatches in the back end, then reads the font RAM once for each of its 16 glyph rows
//   and, when it wraps past the last text row, adds a scroll; the front queue takes further items meanwhile until full.
// Reset: cursor, dirty rectangle and queues clear, width 640, height 480; font store is undefined.
`default_nettype none

module text_console_glyph_renderer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_write,
    input  wire logic [tcgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [12:0]                    cfg_data,
    // input items
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     command,
    input  wire logic [7:0]                     char_code,
    input  wire logic [3:0]                     font_row,
    input  wire logic [7:0]                     font_bits,
    // result items
    output logic                                empty,
    input  wire logic                           pop,
    output logic [1:0]                          kind,
    output logic [11:0]                         pixel_x,
    output logic [11:0]                         pixel_y,
    output logic [7:0]                          pattern,
    output logic                                dirty_valid,
    output logic [12:0]                         rect_left,
    output logic [12:0]                         rect_top,
    output logic [12:0]                         rect_right,
    output logic [12:0]                         rect_bottom,
    output logic                                last
);

    // Configuration registers
    logic [12:0] width_reg, width_next;
    logic [12:0] height_reg, height_next;

    // Derived geometry
    logic [12:0]     used_w;
    logic [12:0]     used_h;
    logic [12:0]     rows_raw;
    tcgr_pkg::geom_t geom;

    // Inter-module signals
    tcgr_pkg::cmd_t                 head;
    logic                           head_valid;
    logic                           head_pop;
    tcgr_pkg::ram_req_t             ram_req;
    logic [7:0]                     ram_rdata;
    logic [tcgr_pkg::OUT_LVL_W-1:0] out_level;
    logic                           out_wr;
    tcgr_pkg::result_t              out_data;
    tcgr_pkg::result_t              res;

    // Register writes; an index beyond the list is ignored
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                tcgr_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_data;
                tcgr_pkg::REG_SCREEN_HEIGHT: height_next = cfg_data;
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Clamp the screen size, then derive text columns and rows
    always_comb
    begin
        if (width_reg < tcgr_pkg::WIDTH_MIN)
            used_w = tcgr_pkg::WIDTH_MIN;
        else if (width_reg > tcgr_pkg::WIDTH_MAX)
            used_w = tcgr_pkg::WIDTH_MAX;
        else
            used_w = width_reg;

        if (height_reg < tcgr_pkg::HEIGHT_MIN)
            used_h = tcgr_pkg::HEIGHT_MIN;
        else if (height_reg > tcgr_pkg::HEIGHT_MAX)
            used_h = tcgr_pkg::HEIGHT_MAX;
        else
            used_h = height_reg;

        rows_raw = 13'(used_h / tcgr_pkg::GLYPH_HEIGHT);

        geom.width  = used_w;
        geom.height = used_h;
        geom.cols   = 10'(used_w / tcgr_pkg::GLYPH_WIDTH);
        if (rows_raw > tcgr_pkg::ROWS_MAX)
            geom.rows = 9'(tcgr_pkg::ROWS_MAX);
        else if (rows_raw == '0)
            geom.rows = 9'd1;
        else
            geom.rows = 9'(rows_raw);
    end

    // Front: accept, classify, queue
    tcgr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .char_code  (char_code),
        .font_row   (font_row),
        .font_bits  (font_bits),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // Back: cursor, dirty tracking, glyph row sequencing
    tcgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .out_level  (out_level),
        .out_wr     (out_wr),
        .out_data   (out_data)
    );

    // Font store: one byte per glyph row
    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (tcgr_pkg::STORE_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Result queue decouples the back end from the consumer
    tcgr_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_data),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res),
        .level   (out_level)
    );

    assign kind        = res.kind;
    assign pixel_x     = res.pixel_x;
    assign pixel_y     = res.pixel_y;
    assign pattern     = res.pattern;
    assign dirty_valid = res.dirty_valid;
    assign rect_left   = res.rect.left;
    assign rect_top    = res.rect.top;
    assign rect_right  = res.rect.right;
    assign rect_bottom = res.rect.bottom;
    assign last        = res.last;

endmodule

`default_nettype wire

// ----- sim/text_console_glyph_renderer_tb.sv -----
// Self-checking testbench for the text console glyph renderer: checker class, drive tasks and top.
// Depends on tcgr_pkg and the RTL under rtl/; reads no files.
`timescale 1ns / 100ps

import tcgr_pkg::*;

// Tracks console state (screen size, cursor, dirty rectangle, font store) and
// holds the result items each accepted input item should produce.
class console_checker;
    logic [12:0] screen_w;
    logic [12:0] screen_h;
    logic [9:0]  cur_col;
    logic [8:0]  cur_row;
    logic        dirty;
    rect_t       dirty_rect;
    logic [7:0]  font [STORE_DEPTH];
    bit          loaded [STORE_DEPTH];
    result_t     step_out[$];
    result_t     pending_results[$];
    int          errors;
    int          items_seen;
    int          n_glyph;
    int          n_scroll;
    int          n_report;

    function new();
        screen_w   = 13'd640;
        screen_h   = 13'd480;
        cur_col    = '0;
        cur_row    = '0;
        dirty      = 1'b0;
        dirty_rect = '0;
        errors     = 0;
        items_seen = 0;
        n_glyph    = 0;
        n_scroll   = 0;
        n_report   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [12:0] value);
        // indexes past the register list are ignored
        if (idx == REG_SCREEN_WIDTH)
            screen_w = value;
        else if (idx == REG_SCREEN_HEIGHT)
            screen_h = value;
    endfunction

    function int unsigned used_w();
        if (screen_w < WIDTH_MIN)
            return WIDTH_MIN;
        if (screen_w > WIDTH_MAX)
            return WIDTH_MAX;
        return screen_w;
    endfunction

    function int unsigned used_h();
        if (screen_h < HEIGHT_MIN)
            return HEIGHT_MIN;
        if (screen_h > HEIGHT_MAX)
            return HEIGHT_MAX;
        return screen_h;
    endfunction

    // clamped size keeps these within 1..512 columns and 1..256 rows
    function int unsigned n_cols();
        return used_w() / GLYPH_WIDTH;
    endfunction

    function int unsigned n_rows();
        return used_h() / GLYPH_HEIGHT;
    endfunction

    function void add_out(logic [1:0] k, int unsigned x, int unsigned y, logic [7:0] pat,
                          logic valid, rect_t rc);
        result_t r;
        r.kind        = k;
        r.pixel_x     = 12'(x);
        r.pixel_y     = 12'(y);
        r.pattern     = pat;
        r.dirty_valid = valid;
        r.rect        = rc;
        r.last        = 1'b0;
        step_out.push_back(r);
    endfunction

    function void grow(int unsigned l, int unsigned t, int unsigned r, int unsigned b);
        if (!dirty)
        begin
            dirty_rect.left   = 13'(l);
            dirty_rect.top    = 13'(t);
            dirty_rect.right  = 13'(r);
            dirty_rect.bottom = 13'(b);
            dirty = 1'b1;
        end
        else
        begin
            if (13'(l) < dirty_rect.left)
                dirty_rect.left = 13'(l);
            if (13'(t) < dirty_rect.top)
                dirty_rect.top = 13'(t);
            if (13'(r) > dirty_rect.right)
                dirty_rect.right = 13'(r);
            if (13'(b) > dirty_rect.bottom)
                dirty_rect.bottom = 13'(b);
        end
    endfunction

    function void next_line();
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= n_rows())
        begin
            cur_row = 9'(n_rows() - 1);
            grow(0, 0, used_w(), used_h());
            add_out(KIND_SCROLL, 0, 0, 8'h00, 1'b0, '0);
        end
    endfunction

    function void put(logic [7:0] code);
        int unsigned cols;
        int unsigned rows;
        int unsigned x;
        int unsigned y;
        cols = n_cols();
        rows = n_rows();
        // screen may have shrunk under the cursor; any put pulls it back in
        if (cur_col >= cols)
            cur_col = 10'(cols - 1);
        if (cur_row >= rows)
            cur_row = 9'(rows - 1);
        if (code == CODE_NULL)
            return;
        if (code == CODE_NEWLINE)
        begin
            next_line();
            return;
        end
        if (code == CODE_BACKSPACE)
        begin
            if (cur_col != 0)
                cur_col = cur_col - 1'b1;
            else if (cur_row != 0)
            begin
                cur_col = 10'(cols - 1);
                cur_row = cur_row - 1'b1;
            end
            return;
        end
        // every 8-bit code lies inside the 256-glyph font, so no blank rows here
        x = cur_col * GLYPH_WIDTH;
        y = cur_row * GLYPH_HEIGHT;
        grow(x, y, x + GLYPH_WIDTH, y + GLYPH_HEIGHT);
        for (int v = 0; v < GLYPH_HEIGHT; v++)
            add_out(KIND_GLYPH, x, y + v, font[int'(code) * GLYPH_HEIGHT + v], 1'b0, '0);
        cur_col = cur_col + 1'b1;
        if (cur_col >= cols)
            next_line();
    endfunction

    // Accepted input item: update state, queue up the results it causes.
    function void note_item(logic [1:0] cmd, logic [7:0] code, logic [3:0] row,
                            logic [7:0] bits);
        result_t r;
        items_seen++;
        step_out.delete();
        case (cmd)
            CMD_PUT:
                put(code);
            CMD_LOAD:
            begin
                font[int'(code) * GLYPH_HEIGHT + int'(row)]   = bits;
                loaded[int'(code) * GLYPH_HEIGHT + int'(row)] = 1'b1;
            end
            CMD_COMMIT:
            begin
                // rectangle is all zero whenever the flag is clear
                add_out(KIND_REPORT, 0, 0, 8'h00, dirty, dirty_rect);
                dirty      = 1'b0;
                dirty_rect = '0;
            end
            default: ;  // unknown command: no effect
        endcase
        if (step_out.size() > 0)
        begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i])
            pending_results.push_back(step_out[i]);
    endfunction

    function bit glyph_ready(logic [7:0] code);
        for (int v = 0; v < GLYPH_HEIGHT; v++)
            if (!loaded[int'(code) * GLYPH_HEIGHT + v])
                return 1'b0;
        return 1'b1;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    task report_error(string what);
        errors++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [12:0] got, logic [12:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Accepted result item: compare with the oldest expected one.
    task check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("unexpected result, kind %0d", got.kind));
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", got.kind, want.kind);
        compare_field("pixel_x", got.pixel_x, want.pixel_x);
        compare_field("pixel_y", got.pixel_y, want.pixel_y);
        compare_field("pattern", got.pattern, want.pattern);
        compare_field("dirty_valid", got.dirty_valid, want.dirty_valid);
        compare_field("rect_left", got.rect.left, want.rect.left);
        compare_field("rect_top", got.rect.top, want.rect.top);
        compare_field("rect_right", got.rect.right, want.rect.right);
        compare_field("rect_bottom", got.rect.bottom, want.rect.bottom);
        compare_field("last", got.last, want.last);
        if (want.kind == KIND_GLYPH)
            n_glyph++;
        else if (want.kind == KIND_SCROLL)
            n_scroll++;
        else
            n_report++;
    endtask
endclass

module text_console_glyph_renderer_tb;

    // Slowest correct run: about 380 items, at most 17 results each, random stalls
    // on both sides and one long hold-off.
    localparam int TIMEOUT_NS    = 10_000_000;
    localparam int SETTLE_CYCLES = 24;    // items with no result may still be in flight
    localparam int PRESSURE_HOLD = 400;   // receiver hold-off that fills the block up

    localparam logic [1:0]           CMD_UNKNOWN  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [12:0]          cfg_data;
    logic                 push;
    logic                 full;
    logic [1:0]           command;
    logic [7:0]           char_code;
    logic [3:0]           font_row;
    logic [7:0]           font_bits;
    logic                 empty;
    logic                 pop;
    logic [1:0]           kind;
    logic [11:0]          pixel_x;
    logic [11:0]          pixel_y;
    logic [7:0]           pattern;
    logic                 dirty_valid;
    logic [12:0]          rect_left;
    logic [12:0]          rect_top;
    logic [12:0]          rect_right;
    logic [12:0]          rect_bottom;
    logic                 last;

    console_checker glyph_check;
    bit             calm;            // no idling on either side while set
    int             rx_hold;         // receiver hold-off, cycles left
    int             settings_used;
    logic [7:0]     setup_glyphs [6];

    text_console_glyph_renderer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .command     (command),
        .char_code   (char_code),
        .font_row    (font_row),
        .font_bits   (font_bits),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pattern     (pattern),
        .dirty_valid (dirty_valid),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .last        (last)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side. Outputs are read right after the edge, so they hold the values
    // the block presented at that edge. pop gets exactly one update per edge.
    initial
    begin : result_sink
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.kind        = kind;
                got.pixel_x     = pixel_x;
                got.pixel_y     = pixel_y;
                got.pattern     = pattern;
                got.dirty_valid = dirty_valid;
                got.rect.left   = rect_left;
                got.rect.top    = rect_top;
                got.rect.right  = rect_right;
                got.rect.bottom = rect_bottom;
                got.last        = last;
                glyph_check.check_result(got);
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Offer one item, hold it until taken. push stays high afterwards so
    // back-to-back items see no bubble; wait_idle lowers it, as may a random idle in the next call.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                             input logic [3:0] row, input logic [7:0] bits);
        while (!calm && $urandom_range(99) < 27)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        command   <= cmd;
        char_code <= code;
        font_row  <= row;
        font_bits <= bits;
        @(posedge clk);
        while (full)
            @(posedge clk);
        glyph_check.note_item(cmd, code, row, bits);
    endtask

    // Caller lowers cfg_write after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        glyph_check.set_reg(idx, value);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (glyph_check.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic new_screen(input logic [12:0] w, input logic [12:0] h);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Full glyph: all sixteen rows, with an all-clear and an all-set row.
    task automatic load_glyph(input logic [7:0] code);
        logic [7:0] bits;
        for (int v = 0; v < GLYPH_HEIGHT; v++)
        begin
            bits = (v == 0) ? 8'h00 : (v == 1) ? 8'hff : 8'($urandom_range(255));
            send_item(CMD_LOAD, code, 4'(v), bits);
        end
    endtask

    // Only codes whose whole glyph was loaded get printed.
    function automatic logic [7:0] pick_printable();
        logic [7:0] code;
        for (int i = 0; i < 16; i++)
        begin
            code = 8'($urandom_range(255));
            if (code != CODE_NULL && code != CODE_NEWLINE && code != CODE_BACKSPACE &&
                glyph_check.glyph_ready(code))
                return code;
        end
        return setup_glyphs[$urandom_range(5)];
    endfunction

    // Mostly printing, with cursor moves, commits, font updates and some noise.
    task automatic random_items(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_item(CMD_PUT, pick_printable(), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 65)
                send_item(CMD_PUT, CODE_NEWLINE, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 72)
                send_item(CMD_PUT, CODE_BACKSPACE, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 75)
                send_item(CMD_PUT, CODE_NULL, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 77)
                send_item(CMD_UNKNOWN, 8'($urandom_range(255)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 88)
                send_item(CMD_COMMIT, 8'($urandom_range(255)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else if (pick < 98)
                send_item(CMD_LOAD, 8'($urandom_range(255)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            else
                load_glyph(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_SCREEN_WIDTH;
        cfg_data      = '0;
        push          = 1'b0;
        pop           = 1'b0;
        command       = CMD_PUT;
        char_code     = CODE_NULL;
        font_row      = '0;
        font_bits     = '0;
        calm          = 1'b0;
        rx_hold       = 0;
        settings_used = 0;
        setup_glyphs  = '{8'h41, 8'h7f, 8'h80, 8'hff, 8'h01, 8'h5a};
        glyph_check   = new();

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 80 x 30 text at reset size
        new_screen(13'd640, 13'd480);

        // Directed: backspace at the origin, commit while clean, unknown command,
        // null code, a load into glyph zero.
        send_item(CMD_PUT, CODE_BACKSPACE, 4'd0, 8'h00);
        send_item(CMD_COMMIT, 8'h00, 4'd0, 8'h00);
        send_item(CMD_UNKNOWN, 8'hff, 4'hf, 8'hff);
        send_item(CMD_PUT, CODE_NULL, 4'hf, 8'haa);
        send_item(CMD_LOAD, CODE_NULL, 4'hf, 8'hff);

        // Font bring-up: whole glyphs for the codes used below
        foreach (setup_glyphs[i])
            load_glyph(setup_glyphs[i]);

        // Directed prints: extreme codes, backspace within a row, newline,
        // backspace across a row start, wrap at the last column, then two commits.
        send_item(CMD_PUT, 8'h41, 4'd0, 8'h00);
        send_item(CMD_PUT, 8'hff, 4'hf, 8'hff);
        send_item(CMD_PUT, 8'h80, 4'd0, 8'h00);
        send_item(CMD_PUT, 8'h7f, 4'd0, 8'h00);
        send_item(CMD_PUT, CODE_BACKSPACE, 4'd0, 8'h00);
        send_item(CMD_PUT, CODE_NEWLINE, 4'd0, 8'h00);
        send_item(CMD_PUT, CODE_BACKSPACE, 4'd0, 8'h00);
        send_item(CMD_PUT, 8'h01, 4'd0, 8'h00);
        send_item(CMD_COMMIT, 8'h00, 4'd0, 8'h00);
        send_item(CMD_COMMIT, 8'h00, 4'd0, 8'h00);
        random_items(30);

        // 3 x 3 text: cursor gets clamped, frequent scrolls. The receiver
        // stops for a long while so the result queue and the input back up.
        new_screen(13'd24, 13'd48);
        rx_hold = PRESSURE_HOLD;
        random_items(30);

        // Smallest screen, one cell: every print wraps and scrolls (17 results)
        new_screen(13'd8, 13'd16);
        send_item(CMD_PUT, 8'h41, 4'd0, 8'h00);
        send_item(CMD_PUT, CODE_NEWLINE, 4'd0, 8'h00);
        send_item(CMD_PUT, CODE_BACKSPACE, 4'd0, 8'h00);
        send_item(CMD_COMMIT, 8'h00, 4'd0, 8'h00);
        send_item(CMD_COMMIT, 8'h00, 4'd0, 8'h00);
        random_items(20);

        // Writes past the register list change nothing
        wait_idle();
        write_reg(REG_SPARE_LO, 13'($urandom_range(8191)));
        write_reg(REG_SPARE_HI, 13'h1fff);
        cfg_write <= 1'b0;

        // Below the minimum: clamps to one cell
        new_screen(13'd3, 13'd15);
        random_items(20);

        // Largest screen, no idling anywhere in this stretch
        new_screen(13'd4096, 13'd4096);
        calm = 1'b1;
        random_items(30);
        calm = 1'b0;

        // All-ones registers clamp to the largest screen
        new_screen(13'h1fff, 13'h1fff);
        random_items(15);

        // Shrink again: 12 x 4 text, cursor likely outside
        new_screen(13'd100, 13'd70);
        random_items(30);

        // Odd sizes: 511 x 2 text
        new_screen(13'd4095, 13'd33);
        random_items(25);

        wait_idle();

        $display("Run covered %0d items and %0d results (%0d glyph rows, %0d scrolls, %0d %s)",
                 glyph_check.items_seen,
                 glyph_check.n_glyph + glyph_check.n_scroll + glyph_check.n_report,
                 glyph_check.n_glyph, glyph_check.n_scroll, glyph_check.n_report,
                 "reports");
        $display("over %0d screen settings from one cell up to 512 x 256 text; %0d mismatches",
                 settings_used, glyph_check.errors);
        if (glyph_check.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- text_console_glyph_renderer.f -----
rtl/tcgr_pkg.sv
rtl/tcgr_ram.sv
rtl/tcgr_front.sv
rtl/tcgr_result_fifo.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer.sv
sim/text_console_glyph_renderer_tb.sv
